// ===== design/lcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Level class run statistics package
// Shared types, register codes and default sizes for the run statistics block.
// ----------------------------------------------------------------------------
package lcrs_pkg;

  localparam int unsigned MV_BITS       = 12;
  localparam int unsigned CFG_DATA_BITS = 12;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CNT_OUT_BITS  = 32;
  localparam int unsigned SUM_BITS      = 44;

  localparam int unsigned COUNT_BITS_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned LOW_BELOW_RST  = 500;
  localparam int unsigned MID_FROM_RST   = 1200;
  localparam int unsigned MID_TO_RST     = 2000;
  localparam int unsigned HIGH_ABOVE_RST = 2600;

  typedef enum logic [1:0] {
    CLASS_LOW       = 2'd0,
    CLASS_MID       = 2'd1,
    CLASS_HIGH      = 2'd2,
    CLASS_UNCERTAIN = 2'd3
  } level_class_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOW_BELOW  = 2'd0,
    REG_MID_FROM   = 2'd1,
    REG_MID_TO     = 2'd2,
    REG_HIGH_ABOVE = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [MV_BITS-1:0] millivolts;
    logic               reading_valid;
  } lcrs_in_t;

  typedef struct packed {
    logic [1:0]              level_class;
    logic                    run_ended;
    logic [1:0]              ended_class;
    logic [CNT_OUT_BITS-1:0] ended_count;
    logic [MV_BITS-1:0]      ended_min;
    logic [MV_BITS-1:0]      ended_max;
    logic [SUM_BITS-1:0]     ended_sum;
  } lcrs_out_t;

  typedef struct packed {
    logic                     we;
    reg_index_e               index;
    logic [CFG_DATA_BITS-1:0] data;
  } lcrs_cfg_t;

endpackage

// ===== design/lcrs_fifo.sv =====
// ----------------------------------------------------------------------------
// Level class run statistics queue
// Small first-in first-out queue that decouples the classifier from the
// run accumulator.
// ----------------------------------------------------------------------------
module lcrs_fifo #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == CNT_BITS'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== design/lcrs_front.sv =====
// ----------------------------------------------------------------------------
// Level class run statistics front end
// Holds the threshold registers and sorts each accepted reading into a class.
// ----------------------------------------------------------------------------
module lcrs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcrs_pkg::lcrs_cfg_t           cfg_i,
  input  logic                          push_i,
  input  lcrs_pkg::lcrs_in_t            in_item_i,
  input  logic                          q_full_i,
  output logic                          q_wr_o,
  output lcrs_pkg::level_class_e        cls_o,
  output logic [lcrs_pkg::MV_BITS-1:0]  value_o
);

  logic [lcrs_pkg::MV_BITS-1:0] low_below_q, mid_from_q, mid_to_q, high_above_q;
  logic [lcrs_pkg::MV_BITS-1:0] cfg_value;
  logic [lcrs_pkg::MV_BITS-1:0] sample;

  assign cfg_value = lcrs_pkg::MV_BITS'(cfg_i.data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_below_q  <= lcrs_pkg::MV_BITS'(lcrs_pkg::LOW_BELOW_RST);
      mid_from_q   <= lcrs_pkg::MV_BITS'(lcrs_pkg::MID_FROM_RST);
      mid_to_q     <= lcrs_pkg::MV_BITS'(lcrs_pkg::MID_TO_RST);
      high_above_q <= lcrs_pkg::MV_BITS'(lcrs_pkg::HIGH_ABOVE_RST);
    end else if (cfg_i.we) begin
      unique case (cfg_i.index)
        lcrs_pkg::REG_LOW_BELOW:  low_below_q  <= cfg_value;
        lcrs_pkg::REG_MID_FROM:   mid_from_q   <= cfg_value;
        lcrs_pkg::REG_MID_TO:     mid_to_q     <= cfg_value;
        lcrs_pkg::REG_HIGH_ABOVE: high_above_q <= cfg_value;
        default: ;
      endcase
    end
  end

  assign sample  = in_item_i.millivolts;
  assign value_o = in_item_i.reading_valid ? sample : '0;
  assign q_wr_o  = push_i && !q_full_i;

  always_comb begin
    priority if (!in_item_i.reading_valid) begin
      cls_o = lcrs_pkg::CLASS_UNCERTAIN;
    end else if (sample < low_below_q) begin
      cls_o = lcrs_pkg::CLASS_LOW;
    end else if (sample >= mid_from_q && sample <= mid_to_q) begin
      cls_o = lcrs_pkg::CLASS_MID;
    end else if (sample > high_above_q) begin
      cls_o = lcrs_pkg::CLASS_HIGH;
    end else begin
      cls_o = lcrs_pkg::CLASS_UNCERTAIN;
    end
  end

endmodule

// ===== design/lcrs_back.sv =====
// ----------------------------------------------------------------------------
// Level class run statistics back end
// Accumulates count, minimum, maximum and sum of the current run and
// registers one result per classified reading.
// ----------------------------------------------------------------------------
module lcrs_back #(
  parameter int unsigned COUNT_BITS  = lcrs_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  lcrs_pkg::level_class_e        cls_i,
  input  logic [lcrs_pkg::MV_BITS-1:0]  value_i,
  output logic                          q_rd_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output lcrs_pkg::lcrs_out_t           out_item_o
);

  localparam int unsigned SB = lcrs_pkg::SUM_BITS;
  localparam int unsigned VB = lcrs_pkg::MV_BITS;

  lcrs_pkg::level_class_e run_class_q, run_class_d;
  logic                   started_q, started_d;
  logic [COUNT_BITS-1:0]  count_q, count_d, base_count;
  logic [VB-1:0]          min_q, min_d, base_min;
  logic [VB-1:0]          max_q, max_d, base_max;
  logic [SB-1:0]          sum_q, sum_d, base_sum;
  logic [SB:0]            sum_ext;
  logic                   ended;
  logic                   out_valid_q, out_valid_d;
  lcrs_pkg::lcrs_out_t    out_q, out_d;

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;
  assign q_rd_o     = !q_empty_i && (!out_valid_q || pop_i);

  assign ended = started_q && (cls_i != run_class_q);

  always_comb begin
    base_count = ended ? '0 : count_q;
    base_min   = ended ? '0 : min_q;
    base_max   = ended ? '0 : max_q;
    base_sum   = ended ? '0 : sum_q;
    sum_ext    = {1'b0, base_sum} + (SB + 1)'(value_i);

    if (base_count == '0) begin
      min_d = value_i;
      max_d = value_i;
    end else begin
      min_d = (value_i < base_min) ? value_i : base_min;
      max_d = (value_i > base_max) ? value_i : base_max;
    end
    sum_d       = sum_ext[SB] ? '1 : sum_ext[SB-1:0];
    count_d     = (base_count == '1) ? base_count : base_count + 1'b1;
    run_class_d = cls_i;
    started_d   = 1'b1;

    out_d             = '0;
    out_d.level_class = cls_i;
    out_d.run_ended   = ended;
    if (ended) begin
      out_d.ended_class = run_class_q;
      out_d.ended_count = lcrs_pkg::CNT_OUT_BITS'(count_q);
      out_d.ended_min   = min_q;
      out_d.ended_max   = max_q;
      out_d.ended_sum   = sum_q;
    end

    out_valid_d = out_valid_q && !pop_i;
    if (q_rd_o) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_class_q <= lcrs_pkg::CLASS_UNCERTAIN;
      started_q   <= 1'b0;
      count_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_rd_o) begin
        run_class_q <= run_class_d;
        started_q   <= started_d;
        count_q     <= count_d;
        min_q       <= min_d;
        max_q       <= max_d;
        sum_q       <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== design/level_class_run_statistics.sv =====
// ----------------------------------------------------------------------------
// Level class run statistics
// Sorts encoder line readings into classes and reports each finished run of
// equal classes with its count, minimum, maximum and sum.
// ----------------------------------------------------------------------------
// Readings enter through a queue-style port: a transaction takes place at a
// rising edge with push high and full low. Results leave the same way: the
// oldest result is shown while empty is low and is taken at an edge with pop
// high. Every reading yields exactly one result.
// The front end classifies a reading in the cycle it is accepted and writes
// it into a queue of QUEUE_DEPTH entries, two by default. The back end takes
// one entry per cycle while its output register is empty or being popped,
// updates the run statistics and registers the result. It accepts one reading
// per cycle while full is low, set by the compare-and-accumulate step of the back end.
// When pop is held low, the output register holds its result, the queue
// fills and full rises; no transaction is lost.
// Reset restores the threshold defaults, empties the queue and the output
// register and starts with no open run. The user must write thresholds through
// cfg_we_i, cfg_index_i and cfg_data_i only while no readings are in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module level_class_run_statistics #(
  parameter int unsigned COUNT_BITS  = lcrs_pkg::COUNT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = lcrs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lcrs_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [lcrs_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 push,
  output logic                                 full,
  input  lcrs_pkg::lcrs_in_t                   in_item_i,
  output logic                                 empty,
  input  logic                                 pop,
  output lcrs_pkg::lcrs_out_t                  out_item_o
);

  localparam int unsigned ITEM_BITS = 2 + lcrs_pkg::MV_BITS;

  lcrs_pkg::lcrs_cfg_t          cfg;
  logic                         q_wr, q_rd, q_empty;
  lcrs_pkg::level_class_e       front_cls;
  logic [lcrs_pkg::MV_BITS-1:0] front_value;
  logic [ITEM_BITS-1:0]         q_wr_data, q_rd_data;
  lcrs_pkg::level_class_e       back_cls;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = lcrs_pkg::reg_index_e'(cfg_index_i);
  assign cfg.data  = cfg_data_i;

  assign q_wr_data = {front_cls, front_value};
  assign back_cls  = lcrs_pkg::level_class_e'(q_rd_data[ITEM_BITS-1 -: 2]);

  lcrs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .push_i    (push),
    .in_item_i (in_item_i),
    .q_full_i  (full),
    .q_wr_o    (q_wr),
    .cls_o     (front_cls),
    .value_o   (front_value)
  );

  lcrs_fifo #(
    .WIDTH(ITEM_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .full_o    (full),
    .rd_i      (q_rd),
    .rd_data_o (q_rd_data),
    .empty_o   (q_empty)
  );

  lcrs_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .cls_i      (back_cls),
    .value_i    (q_rd_data[lcrs_pkg::MV_BITS-1:0]),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

// ===== design/lcrs_checker.sv =====
// ----------------------------------------------------------------------------
// Level class run statistics checker
// Port-level assertions on the reading and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module lcrs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input lcrs_pkg::lcrs_out_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("Waiting result changed or vanished before its transaction.");

  a_ended_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.run_ended) |->
      (out_item_o.ended_class != out_item_o.level_class &&
       out_item_o.ended_count != '0))
    else $error("Reported run has the current class or no readings.");

  a_no_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.run_ended) |->
      (out_item_o.ended_class == '0 && out_item_o.ended_count == '0 &&
       out_item_o.ended_min == '0 && out_item_o.ended_max == '0 &&
       out_item_o.ended_sum == '0))
    else $error("Ended fields are not zero while no run ended.");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> ##2 !empty)
    else $error("No result shown two cycles after an accepted reading.");

endmodule

bind level_class_run_statistics lcrs_checker u_checker (.*);
